### src/class_filtered_priority_queue_top_defines.svh
// assertion macros for the class filtered priority queue
`ifndef CLASS_FILTERED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define CLASS_FILTERED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// combinational check sampled on every clock edge out of reset
`define CFPQ_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cfpq check failed");

// check in the cycle after a trigger
`define CFPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfpq check failed");

`endif

### src/cfpq_pkg.sv
// shared types and constants of the class filtered priority queue
package cfpq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_MISS   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] cls;
    logic [2:0] typ;
    logic [7:0] dur;
  } entry_t;

  typedef struct packed {
    logic push_en;
    logic pop_en;
  } cell_ctrl_t;

endpackage

### src/cfpq_cell.sv
// one slot of the sorted queue, shifting toward either neighbor
module cfpq_cell
  import cfpq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     prev_entry,
  input  entry_t     next_entry,
  input  logic       occ,
  input  logic       prev_le,
  input  logic       hit_in,
  output entry_t     entry,
  output logic       le,
  output logic       hit_out,
  output logic       first
);

  logic match;

  assign le      = !occ || (entry.typ <= new_entry.typ);
  assign match   = occ && (entry.cls == new_entry.cls);
  assign hit_out = hit_in || match;
  assign first   = match && !hit_in;

  always_ff @(posedge clk) begin
    if (ctrl.push_en) begin
      if (prev_le) begin
        entry <= prev_entry;
      end else if (le) begin
        entry <= new_entry;
      end
    end else if (ctrl.pop_en && hit_out) begin
      entry <= next_entry;
    end
  end

endmodule

### src/class_filtered_priority_queue_top.sv
// top level: row of queue cells, count, capacity register and result register
// a result is shown in the cycle after its transaction is accepted
// throughput: one transaction per cycle while out_ready is high, with the
// compare across the cell row done combinationally and the shift on the accepting edge
// reset: synchronous, clears the count, result valid and sets capacity to 16
module class_filtered_priority_queue_top
  import cfpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             opcode,
  input  logic [7:0]       req_class,
  input  logic [2:0]       req_type,
  input  logic [7:0]       duration,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [7:0]       out_class,
  output logic [2:0]       out_type,
  output logic [7:0]       out_duration,
  output logic [4:0]       occupancy
);

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [LIM_W-1:0] cnt_ext;

  entry_t     new_entry;
  entry_t     entries [DEPTH];
  entry_t     popped;
  cell_ctrl_t ctrl;
  logic [DEPTH-1:0] le;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] occ;
  logic [DEPTH:0]   hit;
  logic accept;
  logic full;
  logic found;
  status_t status_next;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign new_entry = '{cls: req_class, typ: req_type, dur: duration};
  assign cnt_ext   = LIM_W'(cnt);
  assign full      = (cnt_ext >= LIM_W'(capacity)) || (cnt == CNT_W'(DEPTH));
  assign found     = hit[DEPTH];
  assign hit[0]    = 1'b0;

  assign ctrl.push_en = accept && (opcode == OP_PUSH) && !full;
  assign ctrl.pop_en  = accept && (opcode == OP_POP) && found;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;
      logic   prev_l;
      assign occ[i] = LIM_W'(i) < cnt_ext;
      if (i == 0) begin : g_head
        assign prev_e = '0;
        assign prev_l = 1'b0;
      end else begin : g_body
        assign prev_e = entries[i-1];
        assign prev_l = le[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_mid
        assign next_e = entries[i+1];
      end
      cfpq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .occ        (occ[i]),
        .prev_le    (prev_l),
        .hit_in     (hit[i]),
        .entry      (entries[i]),
        .le         (le[i]),
        .hit_out    (hit[i+1]),
        .first      (first[i])
      );
    end
  endgenerate

  always_comb begin
    popped = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (first[k]) begin
        popped = popped | entries[k];
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (ctrl.push_en) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (ctrl.pop_en) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_comb begin
    if (opcode == OP_PUSH) begin
      status_next = full ? ST_FULL : ST_PUSHED;
    end else begin
      status_next = found ? ST_POPPED : ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      cnt <= cnt_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      occupancy <= 5'(LIM_W'(cnt_next));
      if (ctrl.pop_en) begin
        out_class    <= popped.cls;
        out_type     <= popped.typ;
        out_duration <= popped.dur;
      end else begin
        out_class    <= '0;
        out_type     <= '0;
        out_duration <= '0;
      end
    end
  end

endmodule

### src/cfpq_checker.sv
// port level checks of the class filtered priority queue, bound to the top level
`include "class_filtered_priority_queue_top_defines.svh"

module cfpq_checker
  import cfpq_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       status,
  input logic [7:0]       out_class,
  input logic [2:0]       out_type,
  input logic [7:0]       out_duration,
  input logic [4:0]       occupancy
);

  // held result transaction keeps its status and occupancy
  `CFPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(occupancy))

  // no popped data unless a pop hit
  `CFPQ_ASSERT_NOW(a_zero_data, !out_valid || status == ST_POPPED || (out_class == 8'd0 && out_type == 3'd0 && out_duration == 8'd0))

  // a successful push leaves at least one entry
  `CFPQ_ASSERT_NOW(a_push_occ, !(out_valid && status == ST_PUSHED) || occupancy != 5'd0)

  // a successful pop leaves room for one more
  `CFPQ_ASSERT_NOW(a_pop_occ, !(out_valid && status == ST_POPPED) || occupancy < 5'(DEPTH))

endmodule

bind class_filtered_priority_queue_top cfpq_checker u_cfpq_checker (.*);

### tb/sv/cfpq_scoreboard_pkg.sv
// scoreboard class that predicts and checks the class filtered priority queue
`timescale 1ns / 100ps

package cfpq_scoreboard_pkg;
  import cfpq_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [7:0] cls;
    logic [2:0] typ;
    logic [7:0] dur;
    logic [4:0] occ;
  } queue_result_t;

  class cfpq_scoreboard;
    entry_t           stored[DEPTH];
    int unsigned      count;
    logic [CAP_W-1:0] capacity;
    queue_result_t    result_q[$];
    int               errors;

    function new();
      count = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function logic [7:0] pick_stored_class();
      return stored[$urandom_range(0, count - 1)].cls;
    endfunction

    // apply one accepted transaction to the shadow queue and store its result
    function void note_request(opcode_t op, logic [7:0] cls, logic [2:0] typ,
                               logic [7:0] dur);
      queue_result_t r;
      int unsigned   limit;
      int unsigned   pos;
      bit            found;
      r = '0;
      limit = (capacity < DEPTH) ? capacity : DEPTH;
      found = 1'b0;
      if (op == OP_PUSH) begin
        if (count >= limit) begin
          r.status = ST_FULL;
        end else begin
          pos = count;
          for (int i = 0; i < count; i++) begin
            if (stored[i].typ <= typ) begin
              pos = i;
              break;
            end
          end
          for (int i = count; i > pos; i--) stored[i] = stored[i - 1];
          stored[pos].cls = cls;
          stored[pos].typ = typ;
          stored[pos].dur = dur;
          count++;
          r.status = ST_PUSHED;
        end
      end else begin
        pos = 0;
        for (int i = 0; i < count; i++) begin
          if (stored[i].cls == cls) begin
            pos = i;
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          r.status = ST_MISS;
        end else begin
          r.status = ST_POPPED;
          r.cls = stored[pos].cls;
          r.typ = stored[pos].typ;
          r.dur = stored[pos].dur;
          for (int i = pos; i + 1 < count; i++) stored[i] = stored[i + 1];
          count--;
        end
      end
      r.occ = count[4:0];
      result_q.push_back(r);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(logic [1:0] st, logic [7:0] cls, logic [2:0] typ,
                               logic [7:0] dur, logic [4:0] occ);
      queue_result_t want;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d, occupancy %0d", $time, st, occ);
        return;
      end
      want = result_q.pop_front();
      if (st !== want.status) report("status", want.status, st);
      if (cls !== want.cls) report("out_class", want.cls, cls);
      if (typ !== want.typ) report("out_type", want.typ, typ);
      if (dur !== want.dur) report("out_duration", want.dur, dur);
      if (occ !== want.occ) report("occupancy", want.occ, occ);
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
// top level testbench of the class filtered priority queue
`timescale 1ns / 100ps

module tb_top;
  import cfpq_pkg::*;
  import cfpq_scoreboard_pkg::*;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic             opcode;
  logic [7:0]       req_class;
  logic [2:0]       req_type;
  logic [7:0]       duration;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       status;
  logic [7:0]       out_class;
  logic [2:0]       out_type;
  logic [7:0]       out_duration;
  logic [4:0]       occupancy;

  cfpq_scoreboard sb = new();
  bit idle_on;
  int hold_cycles;

  class_filtered_priority_queue_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .req_class(req_class),
    .req_type(req_type),
    .duration(duration),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_class(out_class),
    .out_type(out_type),
    .out_duration(out_duration),
    .occupancy(occupancy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result(status, out_class, out_type, out_duration, occupancy);
      end
      if (in_valid && in_ready) begin
        sb.note_request(opcode_t'(opcode), req_class, req_type, duration);
      end
    end
  end

  // result side: random stalls plus an occasional long hold
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = hold_cycles + (idle_on ? $urandom_range(0, 8) : 0);
      hold_cycles = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

  task automatic send_item(opcode_t op, logic [7:0] cls, logic [2:0] typ, logic [7:0] dur);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    req_class <= cls;
    req_type  <= typ;
    duration  <= dur;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic change_capacity(logic [CAP_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(value);
  endtask

  task automatic random_item(int push_pct);
    opcode_t    op;
    logic [7:0] cls;
    op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
    if ($urandom_range(0, 9) < 7) cls = 8'($urandom_range(0, 3));
    else cls = 8'($urandom);
    // most pops ask for a class that is actually stored
    if (op == OP_POP && sb.count != 0 && $urandom_range(0, 9) < 7) begin
      cls = sb.pick_stored_class();
    end
    send_item(op, cls, 3'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(int n, int push_pct, bit idle, int hold_len);
    idle_on = idle;
    for (int i = 0; i < n; i++) begin
      if (hold_len > 0 && i == n / 4) hold_cycles = hold_len;
      random_item(push_pct);
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    opcode      = OP_PUSH;
    req_class   = '0;
    req_type    = '0;
    duration    = '0;
    idle_on     = 1'b1;
    hold_cycles = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    change_capacity(5'd16);
    send_item(OP_POP, 8'h00, 3'd7, 8'hff);
    send_item(OP_PUSH, 8'h00, 3'd0, 8'h00);
    send_item(OP_PUSH, 8'hff, 3'd7, 8'hff);
    send_item(OP_PUSH, 8'h55, 3'd3, 8'haa);
    send_item(OP_PUSH, 8'haa, 3'd3, 8'h55);
    send_item(OP_PUSH, 8'h01, 3'd7, 8'h01);
    send_item(OP_POP, 8'h42, 3'd0, 8'h00);
    send_item(OP_POP, 8'haa, 3'd5, 8'h09);
    send_item(OP_POP, 8'hff, 3'd0, 8'h00);
    send_item(OP_POP, 8'h00, 3'd0, 8'h00);
    send_item(OP_POP, 8'h01, 3'd2, 8'h80);
    send_item(OP_POP, 8'h55, 3'd0, 8'h00);
    send_item(OP_POP, 8'h55, 3'd0, 8'h00);

    change_capacity(5'd1);
    send_item(OP_PUSH, 8'h10, 3'd3, 8'h33);
    send_item(OP_PUSH, 8'h11, 3'd6, 8'h44);
    send_item(OP_POP, 8'h10, 3'd0, 8'h00);
    send_item(OP_POP, 8'h10, 3'd0, 8'h00);

    change_capacity(5'd0);
    send_item(OP_PUSH, 8'h20, 3'd4, 8'h12);
    send_item(OP_POP, 8'h20, 3'd0, 8'h00);

    change_capacity(5'd16);
    random_phase(300, 60, 1'b1, 0);
    change_capacity(5'd31);
    random_phase(200, 80, 1'b1, 60);
    change_capacity(5'd1);
    random_phase(100, 50, 1'b1, 0);
    change_capacity(5'd0);
    random_phase(60, 50, 1'b0, 0);
    change_capacity(5'd5);
    random_phase(200, 55, 1'b1, 80);
    change_capacity(5'd17);
    random_phase(200, 75, 1'b0, 70);
    change_capacity(5'd16);
    random_phase(150, 35, 1'b1, 0);
    change_capacity(5'd8);
    random_phase(100, 60, 1'b0, 0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
